// ===== rtl/core/hdm_pkg.sv =====
// ----------------------------------------------------------------------------
// hdm_pkg
// Shared types, constants and the log-add correction table builder for the
// harmonic distortion meter.
// ----------------------------------------------------------------------------
package hdm_pkg;

	localparam int unsigned HDM_BINS           = 65536;
	localparam int unsigned HDM_LOGADD_ENTRIES = 512;
	localparam int unsigned CFG_W              = 17;
	localparam int unsigned BIN_W              = 16;
	localparam int unsigned DB_W               = 16;

	localparam logic [CFG_W-1:0]       BINS_IN_USE_RST = CFG_W'(48000);
	localparam logic signed [DB_W-1:0] EMPTY_DB        = 16'sh8000;
	localparam logic signed [DB_W-1:0] MAX_DB          = 16'sh7fff;

	localparam logic [63:0] STEP_Q32        = 64'd4173110276;
	localparam logic [63:0] DB_PER_LOG2_Q16 = 64'd50504453;

	typedef enum logic [1:0] {
		CMD_ADD     = 2'd0,
		CMD_ANALYSE = 2'd1,
		CMD_CLEAR   = 2'd2
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD_LA,
		ST_ADD_WR,
		ST_MAX_SCAN,
		ST_SEC_RD,
		ST_SEC_WAIT,
		ST_THD_RD,
		ST_THD_LA,
		ST_THD_ACC,
		ST_DONE
	} state_t;

	// log2(y / 2^30) in Q20 by truncated squaring
	function automatic logic [20:0] log2_q20(input logic [31:0] y);
		logic [63:0] z;
		logic [20:0] res;
		int          k;
		z   = {32'd0, y};
		res = '0;
		if (z >= 64'h8000_0000) begin
			res[20] = 1'b1;
			z       = z >> 1;
		end
		for (k = 19; k >= 0; k--) begin
			z = (z * z) >> 30;
			if (z >= 64'h8000_0000) begin
				res[k] = 1'b1;
				z      = z >> 1;
			end
		end
		return res;
	endfunction

	// correction 10*log10(1 + 10^(-n/80)) in 1/256 dB
	function automatic logic [15:0] logadd_entry(input int unsigned n);
		logic [63:0] x;
		logic [63:0] l;
		logic [63:0] t;
		logic [31:0] y;
		int unsigned i;
		x = 64'h4000_0000;
		for (i = 0; i < n; i++) begin
			x = (x * STEP_Q32 + 64'h8000_0000) >> 32;
		end
		y = 32'(64'h4000_0000 + x);
		l = 64'(log2_q20(y));
		t = (l * DB_PER_LOG2_Q16 + 64'h8_0000_0000) >> 36;
		return t[15:0];
	endfunction

endpackage

// ===== rtl/core/harmonic_distortion_meter.sv =====
// ----------------------------------------------------------------------------
// harmonic_distortion_meter
// Bin store in dB with log-add accumulation and a harmonic distortion scan.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. cmd selects add
//   (power-sum level_db into bin freq_bin), analyse or clear. Adds at or
//   above min(bins_in_use, BINS) are dropped. Analyse raises done for exactly
//   one cycle with fundamental_bin, fundamental_db, second_db, second_valid
//   and thd_db; the receiver cannot hold the result off.
//   Add: a read-modify-write of the bin memory; the next item is taken while
//   the bin is written, and a following add to the same bin is forwarded.
//   Analyse: a peak search over the bins below the bin limit, one bin memory
//   read per cycle, then a read of the bin at 2*f, then the log-add chain over
//   bins from floor(1.5*f) up to the limit, where f is the fundamental (table
//   lookup in a registered ROM).
//   Clear: all BINS bins are set to empty, one bin written per cycle.
//   Reset: bins_in_use returns to 48000 and a clearing pass over all BINS bins
//   runs with busy high; configuration writes are taken meanwhile.
//   Write bins_in_use through cfg_wr_en/cfg_wr_data only while idle.
// ----------------------------------------------------------------------------
module harmonic_distortion_meter
	import hdm_pkg::*;
#(
	parameter int unsigned BINS           = HDM_BINS,
	parameter int unsigned LOGADD_ENTRIES = HDM_LOGADD_ENTRIES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_W-1:0]       cfg_wr_data,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             cmd,
	input  logic [BIN_W-1:0]       freq_bin,
	input  logic signed [DB_W-1:0] level_db,
	output logic                   done,
	output logic [BIN_W-1:0]       fundamental_bin,
	output logic signed [DB_W-1:0] fundamental_db,
	output logic signed [DB_W-1:0] second_db,
	output logic                   second_valid,
	output logic signed [DB_W-1:0] thd_db
);

	localparam int unsigned AW = (BINS > 1) ? $clog2(BINS) : 1;
	localparam int unsigned TW = (LOGADD_ENTRIES > 1) ? $clog2(LOGADD_ENTRIES) : 1;

	state_t state_q, state_d;

	logic [CFG_W-1:0]       bins_in_use_q;
	logic [CFG_W-1:0]       lim;
	logic [AW-1:0]          clr_q;
	logic                   clr_last;
	logic                   accept;
	logic                   rd_ok;

	logic signed [DB_W-1:0] mem [BINS];
	logic signed [DB_W-1:0] rdata_q;
	logic                   mem_re;
	logic [AW-1:0]          mem_raddr;
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic signed [DB_W-1:0] mem_wdata;

	logic [BIN_W-1:0]       fb_q;
	logic signed [DB_W-1:0] lv_q;
	logic                   add_ok_q;
	logic                   fwd_q;
	logic signed [DB_W-1:0] fwd_val_q;

	logic [CFG_W-1:0]       ptr_q;
	logic                   v_s1;
	logic [BIN_W-1:0]       idx_s1;
	logic                   more_q;
	logic signed [DB_W-1:0] best_q;
	logic [BIN_W-1:0]       fund_q;
	logic                   sec_ok_q;
	logic signed [DB_W-1:0] sec_db_q;
	logic signed [DB_W-1:0] thd_q;
	logic [CFG_W-1:0]       second_bin;
	logic [CFG_W-1:0]       thd_start;

	logic [15:0]            corr_tab [LOGADD_ENTRIES];
	logic signed [DB_W-1:0] la_a, la_b;
	logic signed [DB_W-1:0] la_hi, la_lo;
	logic [CFG_W-1:0]       la_dsum;
	logic [11:0]            la_idx;
	logic                   la_byp_s1;
	logic signed [DB_W-1:0] la_bval_s1;
	logic signed [DB_W-1:0] la_hi_s1;
	logic                   la_inr_s1;
	logic [15:0]            la_corr_s1;
	logic [15:0]            la_corr;
	logic [DB_W:0]          la_sum;
	logic signed [DB_W-1:0] la_res;

	for (genvar g = 0; g < LOGADD_ENTRIES; g++) begin : g_tab
		assign corr_tab[g] = logadd_entry(g);
	end

	assign lim        = (bins_in_use_q > CFG_W'(BINS)) ? CFG_W'(BINS) : bins_in_use_q;
	assign clr_last   = (clr_q == AW'(BINS - 1));
	assign accept     = start && !busy;
	assign rd_ok      = (ptr_q < lim);
	assign second_bin = {fund_q, 1'b0};
	assign thd_start  = {1'b0, fund_q} + {2'b00, fund_q[BIN_W-1:1]};

	// log-add, first half: pick operands, look up the correction
	always_comb begin
		if (state_q == ST_ADD_LA) begin
			la_a = fwd_q ? fwd_val_q : rdata_q;
			la_b = lv_q;
		end else begin
			la_a = thd_q;
			la_b = rdata_q;
		end
		la_hi   = (la_a > la_b) ? la_a : la_b;
		la_lo   = (la_a > la_b) ? la_b : la_a;
		la_dsum = CFG_W'({la_hi[DB_W-1], la_hi} - {la_lo[DB_W-1], la_lo}) + CFG_W'(16);
		la_idx  = la_dsum[CFG_W-1:5];
	end

	// log-add, second half: add the correction and saturate, or pass the non-empty operand
	always_comb begin
		la_corr = la_inr_s1 ? la_corr_s1 : 16'd0;
		la_sum  = {la_hi_s1[DB_W-1], la_hi_s1} + {1'b0, la_corr};
		if (la_byp_s1) begin
			la_res = la_bval_s1;
		end else if (la_sum[DB_W] != la_sum[DB_W-1]) begin
			la_res = MAX_DB;
		end else begin
			la_res = la_sum[DB_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		busy      = 1'b1;
		done      = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = ptr_q[AW-1:0];
		mem_we    = 1'b0;
		mem_waddr = fb_q[AW-1:0];
		mem_wdata = la_res;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = EMPTY_DB;
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE, ST_ADD_WR, ST_DONE: begin
				busy = 1'b0;
				if (state_q == ST_ADD_WR) begin
					mem_we = add_ok_q;
				end
				if (state_q == ST_DONE) begin
					done = 1'b1;
				end
				state_d = ST_IDLE;
				if (accept) begin
					case (cmd)
						CMD_ADD: begin
							mem_re    = 1'b1;
							mem_raddr = freq_bin[AW-1:0];
							state_d   = ST_ADD_LA;
						end
						CMD_ANALYSE: state_d = ST_MAX_SCAN;
						CMD_CLEAR:   state_d = ST_CLEAR;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD_LA: begin
				state_d = ST_ADD_WR;
			end
			ST_MAX_SCAN: begin
				mem_re = rd_ok;
				if (!rd_ok && !v_s1) begin
					state_d = ST_SEC_RD;
				end
			end
			ST_SEC_RD: begin
				mem_re    = (second_bin < lim);
				mem_raddr = second_bin[AW-1:0];
				state_d   = ST_SEC_WAIT;
			end
			ST_SEC_WAIT: begin
				state_d = ST_THD_RD;
			end
			ST_THD_RD: begin
				mem_re  = rd_ok;
				state_d = rd_ok ? ST_THD_LA : ST_DONE;
			end
			ST_THD_LA: begin
				mem_re  = rd_ok;
				state_d = ST_THD_ACC;
			end
			ST_THD_ACC: begin
				state_d = more_q ? ST_THD_LA : ST_DONE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_in_use_q <= BINS_IN_USE_RST;
			clr_q         <= '0;
			v_s1          <= 1'b0;
			more_q        <= 1'b0;
			fwd_q         <= 1'b0;
			add_ok_q      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				bins_in_use_q <= cfg_wr_data;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_last ? '0 : clr_q + AW'(1);
			end
			v_s1 <= (state_q == ST_MAX_SCAN) && rd_ok;
			if (state_q == ST_THD_LA) begin
				more_q <= rd_ok;
			end
			if (accept) begin
				fwd_q    <= (state_q == ST_ADD_WR) && add_ok_q && (freq_bin == fb_q);
				add_ok_q <= ({1'b0, freq_bin} < lim);
			end
		end
	end

	always_ff @(posedge clk) begin
		la_byp_s1  <= (la_a == EMPTY_DB) || (la_b == EMPTY_DB);
		la_bval_s1 <= (la_a == EMPTY_DB) ? la_b : la_a;
		la_hi_s1   <= la_hi;
		la_inr_s1  <= ({1'b0, la_idx} < 13'(LOGADD_ENTRIES));
		la_corr_s1 <= corr_tab[la_idx[TW-1:0]];
		if (accept) begin
			fb_q      <= freq_bin;
			lv_q      <= level_db;
			fwd_val_q <= la_res;
			ptr_q     <= '0;
			best_q    <= EMPTY_DB;
			fund_q    <= '0;
		end
		case (state_q)
			ST_MAX_SCAN: begin
				if (rd_ok) begin
					ptr_q <= ptr_q + CFG_W'(1);
				end
				idx_s1 <= ptr_q[BIN_W-1:0];
				if (v_s1 && (rdata_q > best_q)) begin
					best_q <= rdata_q;
					fund_q <= idx_s1;
				end
			end
			ST_SEC_RD: begin
				sec_ok_q <= (second_bin < lim);
			end
			ST_SEC_WAIT: begin
				sec_db_q <= sec_ok_q ? rdata_q : EMPTY_DB;
				ptr_q    <= thd_start;
				thd_q    <= EMPTY_DB;
			end
			ST_THD_RD, ST_THD_LA: begin
				if (rd_ok) begin
					ptr_q <= ptr_q + CFG_W'(1);
				end
			end
			ST_THD_ACC: begin
				thd_q <= la_res;
			end
			default: begin
			end
		endcase
	end

	assign fundamental_bin = fund_q;
	assign fundamental_db  = best_q;
	assign second_db       = sec_db_q;
	assign second_valid    = sec_ok_q;
	assign thd_db          = thd_q;

endmodule

// ===== rtl/core/hdm_checker.sv =====
// ----------------------------------------------------------------------------
// hdm_checker
// Port-level checks for the harmonic distortion meter, bound to the meter module.
// ----------------------------------------------------------------------------
module hdm_checker
	import hdm_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic [1:0]             cmd,
	input logic                   done,
	input logic [BIN_W-1:0]       fundamental_bin,
	input logic signed [DB_W-1:0] fundamental_db,
	input logic signed [DB_W-1:0] second_db,
	input logic                   second_valid
);

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_done_ready: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy while a result is shown");

	a_long_cmd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd == CMD_ANALYSE || cmd == CMD_CLEAR)) |=> busy)
		else $error("analyse or clear item did not raise busy");

	a_second_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !second_valid) |-> (second_db == EMPTY_DB))
		else $error("second level not empty when out of range");

	a_no_energy: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (fundamental_db == EMPTY_DB)) |-> (fundamental_bin == '0))
		else $error("fundamental bin nonzero with no energy");

endmodule

bind harmonic_distortion_meter hdm_checker u_hdm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.cmd             (cmd),
	.done            (done),
	.fundamental_bin (fundamental_bin),
	.fundamental_db  (fundamental_db),
	.second_db       (second_db),
	.second_valid    (second_valid)
);

// ===== dv/tb_harmonic_distortion_meter.sv =====
// ----------------------------------------------------------------------------
// tb_harmonic_distortion_meter
// Self-checking bench for the harmonic distortion meter. A clocked driver
// feeds add, analyse, clear and unused-command items plus bin-limit writes from a plan queue;
// a bit-accurate model of the dB bin store predicts every analyse report, and
// a clocked monitor compares each done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_harmonic_distortion_meter
	import hdm_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned BIN_COUNT   = 65536;
	localparam int unsigned CORR_COUNT  = 512;
	localparam int          NO_ENERGY   = -32768;
	localparam int          TOP_DB      = 32767;
	localparam logic [1:0]  CMD_UNUSED  = 2'd3;
	localparam int unsigned SETTLE      = 8;
	localparam int unsigned TAIL        = 64;
	localparam int unsigned CYCLE_LIMIT = 6000000;
	localparam int unsigned ITEM_TARGET = 1950;
	localparam logic [63:0] ATTEN_Q32   = 64'd4173110276;
	localparam logic [63:0] DB_LOG2_Q16 = 64'd50504453;

	typedef enum logic [1:0] {
		STEP_ITEM,
		STEP_CFG,
		STEP_DRAIN
	} step_kind_t;

	typedef struct {
		step_kind_t             kind;
		logic [1:0]             cmd;
		logic [BIN_W-1:0]       bin;
		logic signed [DB_W-1:0] lvl;
		logic [CFG_W-1:0]       limit;
		int unsigned            gap;
	} plan_step_t;

	typedef struct {
		logic [BIN_W-1:0]       fbin;
		logic signed [DB_W-1:0] fdb;
		logic signed [DB_W-1:0] sdb;
		logic                   sok;
		logic signed [DB_W-1:0] tdb;
	} thd_report_t;

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   cfg_wr_en   = 1'b0;
	logic [CFG_W-1:0]       cfg_wr_data = '0;
	logic                   start       = 1'b0;
	logic                   busy;
	logic [1:0]             cmd         = CMD_ADD;
	logic [BIN_W-1:0]       freq_bin    = '0;
	logic signed [DB_W-1:0] level_db    = '0;
	logic                   done;
	logic [BIN_W-1:0]       fundamental_bin;
	logic signed [DB_W-1:0] fundamental_db;
	logic signed [DB_W-1:0] second_db;
	logic                   second_valid;
	logic signed [DB_W-1:0] thd_db;

	logic signed [DB_W-1:0] bin_db [0:BIN_COUNT-1];
	logic [15:0]            corr_db [0:CORR_COUNT-1];
	logic [CFG_W-1:0]       limit_reg;

	thd_report_t  reports_due[$];
	plan_step_t   plan[$];
	plan_step_t   cur;
	bit           cur_ok      = 1'b0;
	bit           item_live   = 1'b0;
	bit           run         = 1'b0;
	bit           no_idle     = 1'b0;
	int unsigned  gap_left    = 0;
	int unsigned  settle      = 0;
	int unsigned  items_planned = 0;
	int unsigned  mismatches  = 0;

	harmonic_distortion_meter dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.start           (start),
		.busy            (busy),
		.cmd             (cmd),
		.freq_bin        (freq_bin),
		.level_db        (level_db),
		.done            (done),
		.fundamental_bin (fundamental_bin),
		.fundamental_db  (fundamental_db),
		.second_db       (second_db),
		.second_valid    (second_valid),
		.thd_db          (thd_db)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [20:0] log2_ratio_q20(input logic [31:0] y);
		logic [63:0] acc;
		logic [20:0] bits;
		int          k;
		acc  = {32'd0, y};
		bits = '0;
		for (k = 20; k >= 0; k--) begin
			if (k != 20)
				acc = (acc * acc) >> 30;
			if (acc[63:31] != '0) begin
				bits[k] = 1'b1;
				acc     = acc >> 1;
			end
		end
		return bits;
	endfunction

	function automatic logic signed [DB_W-1:0] clamp_db(input int v);
		if (v > TOP_DB)
			return 16'sh7fff;
		if (v < NO_ENERGY)
			return 16'sh8000;
		return 16'(v);
	endfunction

	function automatic logic signed [DB_W-1:0] power_sum(input logic signed [DB_W-1:0] a,
		input logic signed [DB_W-1:0] b);
		int hi;
		int lo;
		int idx;
		int r;
		if (a == 16'sh8000)
			return b;
		if (b == 16'sh8000)
			return a;
		hi  = (a > b) ? a : b;
		lo  = (a > b) ? b : a;
		idx = (hi - lo + 16) >> 5;
		r   = hi + ((idx < CORR_COUNT) ? int'(corr_db[idx]) : 0);
		if (r > TOP_DB)
			r = TOP_DB;
		return 16'(r);
	endfunction

	function automatic void apply_item(input logic [1:0] c, input logic [BIN_W-1:0] fb,
		input logic signed [DB_W-1:0] lv);
		int unsigned lim;
		int unsigned i;
		int unsigned fund;
		int unsigned twice;
		int unsigned first_thd;
		int          best;
		logic signed [DB_W-1:0] acc;
		thd_report_t rep;
		lim = (limit_reg > BIN_COUNT) ? BIN_COUNT : limit_reg;
		case (c)
			CMD_ADD: begin
				if (fb < lim)
					bin_db[fb] = power_sum(bin_db[fb], lv);
			end
			CMD_CLEAR: begin
				for (i = 0; i < BIN_COUNT; i++)
					bin_db[i] = 16'sh8000;
			end
			CMD_ANALYSE: begin
				best = NO_ENERGY;
				fund = 0;
				for (i = 0; i < lim; i++) begin
					if (bin_db[i] > best) begin
						best = bin_db[i];
						fund = i;
					end
				end
				twice    = fund * 2;
				rep.fbin = 16'(fund);
				rep.fdb  = 16'(best);
				rep.sok  = (twice < lim);
				rep.sdb  = rep.sok ? bin_db[twice] : 16'sh8000;
				first_thd = fund * 3 / 2;
				acc = 16'sh8000;
				for (i = first_thd; i < lim; i++)
					acc = power_sum(acc, bin_db[i]);
				rep.tdb = acc;
				reports_due.push_back(rep);
			end
			default: begin
			end
		endcase
	endfunction

	function automatic int unsigned idle_gap();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	task automatic push_item(input logic [1:0] c, input int unsigned fb, input int lv);
		plan_step_t s;
		s.kind  = STEP_ITEM;
		s.cmd   = c;
		s.bin   = 16'(fb);
		s.lvl   = clamp_db(lv);
		s.limit = '0;
		s.gap   = idle_gap();
		plan.push_back(s);
		if (c != CMD_UNUSED)
			items_planned++;
	endtask

	task automatic push_cfg(input int unsigned v);
		plan_step_t s;
		s.kind  = STEP_CFG;
		s.cmd   = CMD_ADD;
		s.bin   = '0;
		s.lvl   = '0;
		s.limit = CFG_W'(v);
		s.gap   = idle_gap();
		plan.push_back(s);
	endtask

	task automatic push_drain();
		plan_step_t s;
		s.kind  = STEP_DRAIN;
		s.cmd   = CMD_ADD;
		s.bin   = '0;
		s.lvl   = '0;
		s.limit = '0;
		s.gap   = 0;
		plan.push_back(s);
	endtask

	always @(posedge clk) begin : drive
		logic nstart;
		logic nwr;
		if (run) begin
			if (start && !busy) begin
				apply_item(cmd, freq_bin, level_db);
				item_live = 1'b0;
			end
			nstart = item_live;
			nwr    = 1'b0;
			if (!item_live) begin
				if (!cur_ok && plan.size() != 0) begin
					cur      = plan.pop_front();
					cur_ok   = 1'b1;
					gap_left = cur.gap;
					settle   = 0;
				end
				if (cur_ok) begin
					if (gap_left != 0) begin
						gap_left--;
					end else begin
						case (cur.kind)
							STEP_ITEM: begin
								cmd       <= cur.cmd;
								freq_bin  <= cur.bin;
								level_db  <= cur.lvl;
								nstart    = 1'b1;
								item_live = 1'b1;
								cur_ok    = 1'b0;
							end
							STEP_CFG: begin
								cfg_wr_data <= cur.limit;
								nwr         = 1'b1;
								limit_reg   = cur.limit;
								cur_ok      = 1'b0;
							end
							default: begin
								if (reports_due.size() == 0) begin
									if (settle < SETTLE)
										settle++;
									else if (!busy)
										cur_ok = 1'b0;
								end
							end
						endcase
					end
				end
			end
			start     <= nstart;
			cfg_wr_en <= nwr;
		end
	end

	always @(posedge clk) begin : check
		thd_report_t want;
		bit          bad;
		if (arst_n && done) begin
			if (reports_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected report: bin %0d fund %0d second %0d/%0b thd %0d",
						fundamental_bin, fundamental_db, second_db, second_valid, thd_db);
			end else begin
				want = reports_due.pop_front();
				bad  = (fundamental_bin !== want.fbin) || (fundamental_db !== want.fdb) ||
					(second_db !== want.sdb) || (second_valid !== want.sok) ||
					(thd_db !== want.tdb);
				if (bad) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("report mismatch at %0t:", $realtime);
						$display("  expected bin %0d fund %0d second %0d/%0b thd %0d",
							want.fbin, want.fdb, want.sdb, want.sok, want.tdb);
						$display("  actual   bin %0d fund %0d second %0d/%0b thd %0d",
							fundamental_bin, fundamental_db, second_db, second_valid, thd_db);
					end
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin : main
		logic [63:0] x;
		logic [63:0] l;
		int unsigned i;
		int unsigned phase;
		int unsigned lim_w;
		int unsigned f;
		int unsigned h;
		int unsigned r;
		int          top;

		x = 64'h4000_0000;
		for (i = 0; i < CORR_COUNT; i++) begin
			l          = 64'(log2_ratio_q20(32'(64'h4000_0000 + x)));
			corr_db[i] = 16'((l * DB_LOG2_Q16 + 64'h8_0000_0000) >> 36);
			x          = (x * ATTEN_Q32 + 64'h8000_0000) >> 32;
		end
		for (i = 0; i < BIN_COUNT; i++)
			bin_db[i] = 16'sh8000;
		limit_reg = CFG_W'(48000);

		// default limit: saturation, drops at and above the limit
		push_item(CMD_ADD, 47999, TOP_DB);
		push_item(CMD_ADD, 47999, TOP_DB);
		push_item(CMD_ADD, 48000, 100);
		push_item(CMD_ADD, 65535, 200);
		push_item(CMD_ANALYSE, 0, 0);
		push_drain();
		// limit above the bin count, tie at the top level
		push_cfg(131071);
		push_item(CMD_ADD, 65535, TOP_DB);
		push_item(CMD_ADD, 0, -32767);
		push_item(CMD_ANALYSE, 65535, -1);
		push_drain();
		push_item(CMD_CLEAR, 0, 0);
		push_drain();
		// zero limit
		push_cfg(0);
		push_item(CMD_ADD, 0, 500);
		push_item(CMD_ANALYSE, 0, 0);
		push_drain();
		// single bin: empty store, empty level
		push_cfg(1);
		push_item(CMD_ANALYSE, 0, 0);
		push_item(CMD_ADD, 0, NO_ENERGY);
		push_item(CMD_ADD, 0, -32767);
		push_item(CMD_ANALYSE, 0, 0);
		push_drain();
		// small store: far and equal log-add operands, empty THD range
		push_cfg(16);
		push_item(CMD_ADD, 4, 1000);
		push_item(CMD_ADD, 4, -32767);
		push_item(CMD_ADD, 8, 500);
		push_item(CMD_ADD, 6, 990);
		push_item(CMD_ADD, 6, 990);
		push_item(CMD_ADD, 12, -2000);
		push_item(CMD_UNUSED, 5, 5);
		push_item(CMD_ANALYSE, 0, 0);
		push_item(CMD_ADD, 15, TOP_DB);
		push_item(CMD_ANALYSE, 0, 0);

		phase = 0;
		while (items_planned < ITEM_TARGET) begin
			push_drain();
			r = $urandom_range(0, 9);
			if (r == 0)
				lim_w = $urandom_range(1, 15);
			else if (r == 1)
				lim_w = $urandom_range(0, 1) ? 256 : 128;
			else
				lim_w = $urandom_range(16, 400);
			push_cfg(lim_w);
			no_idle = ($urandom_range(0, 4) == 0);
			if (phase == 7 || phase == 19 || phase == 31)
				push_item(CMD_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 65535));
			repeat ($urandom_range(3, 6)) begin
				if ($urandom_range(0, 9) < 8) begin
					if ($urandom_range(0, 3) == 0)
						f = $urandom_range(0, lim_w - 1);
					else
						f = $urandom_range(0, (lim_w - 1) / 2);
					if ($urandom_range(0, 9) == 0)
						top = TOP_DB - int'($urandom_range(0, 300));
					else
						top = int'($urandom_range(0, 65535)) - 32768;
					push_item(CMD_ADD, f, top);
					for (h = 2; h <= 6; h++) begin
						if (h * f < lim_w && $urandom_range(0, 3) != 0)
							push_item(CMD_ADD, h * f, top - int'($urandom_range(256, 20000)));
					end
					repeat ($urandom_range(0, 6))
						push_item(CMD_ADD, $urandom_range(0, lim_w - 1),
							top - int'($urandom_range(0, 24000)));
					if ($urandom_range(0, 3) == 0)
						push_item(CMD_ADD, f, top);
					push_item(CMD_ANALYSE, $urandom_range(0, 65535), $urandom_range(0, 65535));
				end else begin
					repeat ($urandom_range(2, 8)) begin
						r = $urandom_range(0, 9);
						if (r < 6)
							push_item(CMD_ADD, $urandom_range(0, 65535),
								int'($urandom_range(0, 65535)) - 32768);
						else if (r < 8)
							push_item(CMD_ANALYSE, $urandom_range(0, 65535), 0);
						else if (r < 9)
							push_item(CMD_UNUSED, $urandom_range(0, 65535),
								int'($urandom_range(0, 65535)) - 32768);
						else
							push_item(CMD_ADD, $urandom_range(0, lim_w - 1),
								int'($urandom_range(0, 65535)) - 32768);
					end
				end
				if ($urandom_range(0, 19) == 0)
					push_drain();
			end
			phase++;
		end
		push_drain();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		run    <= 1'b1;
		@(posedge clk);
		while (plan.size() != 0 || cur_ok || item_live)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (mismatches == 0 && reports_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/hdm_pkg.sv
rtl/core/harmonic_distortion_meter.sv
rtl/core/hdm_checker.sv
dv/tb_harmonic_distortion_meter.sv
